// ===== rtl/core/mbe_pkg.sv =====
// shared types, constants and fixed-point helpers of the four-lane escape-time unit
// no dependencies
package mbe_pkg;

  localparam int LANES      = 4;
  localparam int FRAC_BITS  = 28;
  localparam int WBITS      = FRAC_BITS + 4;
  localparam int COORD_BITS = 12;
  localparam int CNT_BITS   = 16;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int STEP_BITS  = 31;
  localparam int PROD_BITS  = 2 * WBITS;

  localparam logic [CFG_AW-1:0] REG_X_LOWER  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_Y_LOWER  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_X_STEP   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_ITER = 3'd4;

  localparam logic signed [WBITS-1:0] QMAX = {1'b0, {(WBITS-1){1'b1}}};
  localparam logic signed [WBITS-1:0] QMIN = {1'b1, {(WBITS-1){1'b0}}};
  localparam logic [WBITS+1:0] FOUR = (WBITS+2)'(4) << FRAC_BITS;

  typedef logic signed [WBITS-1:0] q_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count_lane0;
    logic [CNT_BITS-1:0] count_lane1;
    logic [CNT_BITS-1:0] count_lane2;
    logic [CNT_BITS-1:0] count_lane3;
    logic                inside_lane0;
    logic                inside_lane1;
    logic                inside_lane2;
    logic                inside_lane3;
  } out_word_t;

  typedef enum logic [1:0] {ST_IDLE, ST_MAP, ST_RUN, ST_OUT} state_t;

  // lane control from sequencer
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctl_t;

  // saturate a wide signed value into the working range
  function automatic q_t sat_w(input logic signed [PROD_BITS:0] v);
    if (v > $signed({{(PROD_BITS-WBITS+1){1'b0}}, QMAX})) sat_w = QMAX;
    else if (v < $signed({{(PROD_BITS-WBITS+1){1'b1}}, QMIN})) sat_w = QMIN;
    else sat_w = v[WBITS-1:0];
  endfunction

  // exact product, magnitude truncated, saturated
  function automatic q_t qmul(input q_t a, input q_t b);
    logic          neg;
    logic [WBITS-1:0] ua, ub;
    logic [PROD_BITS-1:0] p, r;
    logic [PROD_BITS-1:0] lim;
    neg = a[WBITS-1] ^ b[WBITS-1];
    ua  = a[WBITS-1] ? WBITS'(-a) : a;
    ub  = b[WBITS-1] ? WBITS'(-b) : b;
    p   = ua * ub;
    r   = p >> FRAC_BITS;
    lim = neg ? PROD_BITS'({1'b0, QMAX}) + PROD_BITS'(1) : PROD_BITS'({1'b0, QMAX});
    if (r >= lim) qmul = neg ? QMIN : QMAX;
    else qmul = neg ? WBITS'(-r[WBITS-1:0]) : r[WBITS-1:0];
  endfunction

endpackage

// ===== rtl/core/mbe_lane.sv =====
// one escape-time lane: z = z^2 + c iterated as a square phase and an update phase
// depends on mbe_pkg
module mbe_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  mbe_pkg::lane_ctl_t ctl,
  input  logic              phase,
  input  mbe_pkg::q_t       re,
  input  mbe_pkg::q_t       im,
  input  logic [mbe_pkg::CNT_BITS-1:0] iter,
  input  logic [mbe_pkg::CNT_BITS-1:0] max_iter,
  output logic              done,
  output logic [mbe_pkg::CNT_BITS-1:0] count
);
  import mbe_pkg::*;

  q_t a_r, b_r, a_nxt, b_nxt;
  q_t aa_r, bb_r, ab_r;
  logic done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  q_t na, nb, sa, sb;
  logic [WBITS+1:0] mag2;

  // phase 0: square current z and test it (it is the result of iteration iter-1,
  // so nothing is tested while iter is 0); phase 1: form new z
  always_comb begin
    na = sat_w((PROD_BITS+1)'(aa_r) - (PROD_BITS+1)'(bb_r));
    nb = sat_w((PROD_BITS+1)'(ab_r) + (PROD_BITS+1)'(ab_r));
    a_nxt = sat_w((PROD_BITS+1)'(na) + (PROD_BITS+1)'(re));
    b_nxt = sat_w((PROD_BITS+1)'(nb) + (PROD_BITS+1)'(im));
    sa = qmul(a_r, a_r);
    sb = qmul(b_r, b_r);
    mag2 = (WBITS+2)'($signed(sa)) + (WBITS+2)'($signed(sb));
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (ctl.step && !phase && !done_r && (iter != '0) &&
        $signed(mag2) > $signed(FOUR)) begin
      done_nxt = 1'b1;
      cnt_nxt  = iter - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (ctl.load) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= re;
      b_r   <= im;
      cnt_r <= max_iter;
    end else if (ctl.step && !done_r) begin
      if (!phase) begin
        aa_r <= sa;
        bb_r <= sb;
        ab_r <= qmul(a_r, b_r);
      end else begin
        a_r <= a_nxt;
        b_r <= b_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign done  = done_r;
  assign count = cnt_r;

endmodule

// ===== rtl/core/mandelbrot_escape_time_4lane_unit.sv =====
// top level of the four-lane escape-time unit: registers, sequencer, lanes, merge
// depends on mbe_pkg and mbe_lane
//
// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_ready | in_word_t (column, row)
// out_    | output    | out_valid/out_ready | out_word_t (counts, inside flags)
// cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// each iteration is a square/test pass and an update pass, and a last square/test pass
// checks the final update; the run ends early when every lane escaped before max_iter.
// a word is taken in idle and mapped, and after the run the output state returns to idle;
// with max_iter 0 the run is skipped.
// the result sits in an output register, so the next word is taken while it waits.
// reset (rst_n low, synchronous) restores register defaults.
module mandelbrot_escape_time_4lane_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbe_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mbe_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [mbe_pkg::CFG_AW-1:0] cfg_index,
  input  logic [mbe_pkg::CFG_DW-1:0] cfg_wdata
);
  import mbe_pkg::*;

  // configuration registers
  q_t x_lower_r, y_lower_r;
  logic [STEP_BITS-1:0] x_step_r, y_step_r;
  logic [CNT_BITS-1:0] max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lower_r  <= -q_t'(536870912);
      y_lower_r  <= -q_t'(402653184);
      x_step_r   <= STEP_BITS'(786432);
      y_step_r   <= STEP_BITS'(786432);
      max_iter_r <= CNT_BITS'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_LOWER:  x_lower_r  <= cfg_wdata[WBITS-1:0];
        REG_Y_LOWER:  y_lower_r  <= cfg_wdata[WBITS-1:0];
        REG_X_STEP:   x_step_r   <= cfg_wdata[STEP_BITS-1:0];
        REG_Y_STEP:   y_step_r   <= cfg_wdata[STEP_BITS-1:0];
        REG_MAX_ITER: max_iter_r <= cfg_wdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state_r, state_nxt;
  logic phase_r;
  logic [CNT_BITS-1:0] iter_r;
  in_word_t word_r;
  q_t re_r [LANES];
  q_t im_r;
  logic [LANES-1:0] done_w;
  logic [CNT_BITS-1:0] cnt_w [LANES];
  logic out_valid_r;
  out_word_t out_r;
  lane_ctl_t ctl;
  logic iter_end, all_done;

  assign all_done  = &done_w;
  // every iteration run, only the final test pass left
  assign iter_end  = (iter_r == max_iter_r);
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MAP;
      ST_MAP:  state_nxt = (max_iter_r == '0) ? ST_OUT : ST_RUN;
      ST_RUN:  if ((!phase_r && iter_end) || (phase_r && all_done)) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load = (state_r == ST_MAP);
    ctl.step = (state_r == ST_RUN);
  end

  // pixel mapping: one multiply per coordinate, saturating sum
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) word_r <= in_data;
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      re_r[k] = sat_w((PROD_BITS+1)'(x_lower_r) +
        (PROD_BITS+1)'({1'b0, (COORD_BITS+1)'(word_r.column) + (COORD_BITS+1)'(k)}
                       * {1'b0, x_step_r}));
    end
    im_r = sat_w((PROD_BITS+1)'(y_lower_r) +
      (PROD_BITS+1)'({1'b0, word_r.row} * {1'b0, y_step_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load) begin
        phase_r <= 1'b0;
        iter_r  <= '0;
      end else if (ctl.step) begin
        phase_r <= ~phase_r;
        if (phase_r) iter_r <= iter_r + CNT_BITS'(1);
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mbe_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .phase(phase_r),
      .re(re_r[k]), .im(im_r), .iter(iter_r), .max_iter(max_iter_r),
      .done(done_w[k]), .count(cnt_w[k])
    );
  end

  // merge lanes into the output register
  logic load_out;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.count_lane0  <= cnt_w[0];
      out_r.count_lane1  <= cnt_w[1];
      out_r.count_lane2  <= cnt_w[2];
      out_r.count_lane3  <= cnt_w[3];
      out_r.inside_lane0 <= ~done_w[0];
      out_r.inside_lane1 <= ~done_w[1];
      out_r.inside_lane2 <= ~done_w[2];
      out_r.inside_lane3 <= ~done_w[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== dv/mandelbrot_escape_time_4lane_unit_tb.sv =====
// self-checking test of the four-lane escape-time unit: directed table, random words, hold-off
// depends on mbe_pkg and the rtl of mandelbrot_escape_time_4lane_unit
module mandelbrot_escape_time_4lane_unit_tb;
  import mbe_pkg::*;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam longint Q_FOUR = 64'sd4 <<< FRAC_BITS;
  localparam int LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // own copy of the registers, as the block should hold them
  longint m_xl = -64'sd536870912;
  longint m_yl = -64'sd402653184;
  longint m_xs = 64'sd786432;
  longint m_ys = 64'sd786432;
  int unsigned m_mi = 256;

  out_word_t pending_counts[$];
  int unsigned mismatches = 0;
  int unsigned cycle_no = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // one row of the directed table; wr set means load the register values first
  typedef struct packed {
    logic        wr;
    logic [31:0] xl;
    logic [31:0] yl;
    logic [31:0] xs;
    logic [31:0] ys;
    logic [15:0] mi;
    in_word_t    w;
    logic        known;
    out_word_t   res;
  } dir_row_t;

  dir_row_t rows[0:13];

  mandelbrot_escape_time_4lane_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint q_sat(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // exact product, magnitude cut to the fraction bits, then saturated
  function automatic longint q_mul(longint a, longint b);
    bit neg;
    logic [63:0] ua, ub, p, r, lim;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = ua * ub;
    r = p >> FRAC_BITS;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (r >= lim) return neg ? Q_LO : Q_HI;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // escape iteration and inside flag of the four lanes of one word
  function automatic out_word_t escape_counts(in_word_t w);
    longint re[4], a[4], b[4];
    longint im, na, nb, ab;
    int unsigned cnt[4];
    bit done[4];
    bit all;
    out_word_t r;
    im = q_sat(q_sat(m_yl) + longint'(w.row) * m_ys);
    for (int k = 0; k < 4; k++) begin
      re[k] = q_sat(q_sat(m_xl) + (longint'(w.column) + k) * m_xs);
      a[k] = re[k];
      b[k] = im;
      cnt[k] = m_mi;
      done[k] = 1'b0;
    end
    for (int unsigned i = 0; i < m_mi; i++) begin
      all = 1'b1;
      for (int k = 0; k < 4; k++) begin
        if (!done[k]) begin
          na = q_sat(q_mul(a[k], a[k]) - q_mul(b[k], b[k]));
          ab = q_mul(a[k], b[k]);
          nb = q_sat(ab + ab);
          a[k] = q_sat(na + re[k]);
          b[k] = q_sat(nb + im);
          // exactly 4.0 stays inside
          if (q_mul(a[k], a[k]) + q_mul(b[k], b[k]) > Q_FOUR) begin
            done[k] = 1'b1;
            cnt[k] = i;
          end else begin
            all = 1'b0;
          end
        end
      end
      if (all) break;
    end
    r.count_lane0 = cnt[0][15:0];
    r.count_lane1 = cnt[1][15:0];
    r.count_lane2 = cnt[2][15:0];
    r.count_lane3 = cnt[3][15:0];
    r.inside_lane0 = !done[0];
    r.inside_lane1 = !done[1];
    r.inside_lane2 = !done[2];
    r.inside_lane3 = !done[3];
    return r;
  endfunction

  // same count and flag on every lane
  function automatic out_word_t all_lanes(logic [15:0] c, logic ins);
    return {c, c, c, c, ins, ins, ins, ins};
  endfunction

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // checker: handshake seen at the falling edge is taken at the next rising edge
  always @(negedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_counts.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        e = pending_counts.pop_front();
        if (out_data.count_lane0 !== e.count_lane0) begin
          $error("count_lane0 exp %0d got %0d", e.count_lane0, out_data.count_lane0);
          mismatches++;
        end
        if (out_data.count_lane1 !== e.count_lane1) begin
          $error("count_lane1 exp %0d got %0d", e.count_lane1, out_data.count_lane1);
          mismatches++;
        end
        if (out_data.count_lane2 !== e.count_lane2) begin
          $error("count_lane2 exp %0d got %0d", e.count_lane2, out_data.count_lane2);
          mismatches++;
        end
        if (out_data.count_lane3 !== e.count_lane3) begin
          $error("count_lane3 exp %0d got %0d", e.count_lane3, out_data.count_lane3);
          mismatches++;
        end
        if (out_data.inside_lane0 !== e.inside_lane0) begin
          $error("inside_lane0 exp %0d got %0d", e.inside_lane0, out_data.inside_lane0);
          mismatches++;
        end
        if (out_data.inside_lane1 !== e.inside_lane1) begin
          $error("inside_lane1 exp %0d got %0d", e.inside_lane1, out_data.inside_lane1);
          mismatches++;
        end
        if (out_data.inside_lane2 !== e.inside_lane2) begin
          $error("inside_lane2 exp %0d got %0d", e.inside_lane2, out_data.inside_lane2);
          mismatches++;
        end
        if (out_data.inside_lane3 !== e.inside_lane3) begin
          $error("inside_lane3 exp %0d got %0d", e.inside_lane3, out_data.inside_lane3);
          mismatches++;
        end
      end
    end
  end

  // offer one word; entered just after a rising edge, returns at the accepting edge
  task automatic send_word(in_word_t w, bit known, out_word_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_counts.push_back(known ? res : escape_counts(w));
  endtask

  // sender pauses until every expected word has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // load all five registers, one write per cycle; block must be idle
  task automatic set_config(logic [31:0] xl, logic [31:0] yl, logic [31:0] xs,
                            logic [31:0] ys, logic [15:0] mi);
    cfg_we <= 1'b1;
    cfg_index <= REG_X_LOWER;
    cfg_wdata <= xl;
    @(posedge clk);
    cfg_index <= REG_Y_LOWER;
    cfg_wdata <= yl;
    @(posedge clk);
    cfg_index <= REG_X_STEP;
    cfg_wdata <= {1'b0, xs[30:0]};
    @(posedge clk);
    cfg_index <= REG_Y_STEP;
    cfg_wdata <= {1'b0, ys[30:0]};
    @(posedge clk);
    cfg_index <= REG_MAX_ITER;
    cfg_wdata <= {16'd0, mi};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_xl = longint'($signed(xl));
    m_yl = longint'($signed(yl));
    m_xs = longint'(xs[30:0]);
    m_ys = longint'(ys[30:0]);
    m_mi = mi;
  endtask

  initial begin
    logic [31:0] rxl, ryl, rxs, rys;
    logic [15:0] rmi;
    // reset values first, then the extremes
    rows[0]  = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, {12'd0, 12'd0}, 1'b0, '0};
    rows[1]  = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, {12'd4092, 12'd4095}, 1'b0, '0};
    // column not a multiple of four
    rows[2]  = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, {12'd333, 12'd200}, 1'b0, '0};
    rows[3]  = '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, {12'd4095, 12'd0}, 1'b0, '0};
    // far corner: every lane out at once
    rows[4]  = '{1'b1, 32'h7fffffff, 32'h7fffffff, 32'd0, 32'd0, 16'd256,
                 {12'd5, 12'd9}, 1'b1, all_lanes(16'd0, 1'b0)};
    rows[5]  = '{1'b1, 32'h80000000, 32'h80000000, 32'd0, 32'd0, 16'd256,
                 {12'd0, 12'd0}, 1'b1, all_lanes(16'd0, 1'b0)};
    // origin never escapes
    rows[6]  = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 16'd1,
                 {12'd0, 12'd0}, 1'b1, all_lanes(16'd1, 1'b1)};
    // minus two sits at |z|^2 of exactly four for ever
    rows[7]  = '{1'b1, 32'he0000000, 32'd0, 32'd0, 32'd0, 16'd8,
                 {12'd4095, 12'd4095}, 1'b1, all_lanes(16'd8, 1'b1)};
    // largest steps saturate the coordinates
    rows[8]  = '{1'b1, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'd20,
                 {12'd4095, 12'd4095}, 1'b0, '0};
    rows[9]  = '{1'b1, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'd20,
                 {12'd0, 12'd1}, 1'b0, '0};
    rows[10] = '{1'b1, 32'hf8000000, 32'hfc000000, 32'h00400000, 32'h00400000, 16'd40,
                 {12'd2730, 12'd1365}, 1'b0, '0};
    rows[11] = '{1'b1, 32'hf8000000, 32'hfc000000, 32'h00400000, 32'h00400000, 16'd40,
                 {12'd1365, 12'd2730}, 1'b0, '0};
    // deepest iteration count, once
    rows[12] = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 16'd65535,
                 {12'd100, 12'd100}, 1'b1, all_lanes(16'd65535, 1'b1)};
    rows[13] = '{1'b1, 32'hd0000000, 32'he8000000, 32'h00100000, 32'h00100000, 16'd100,
                 {12'd8, 12'd12}, 1'b0, '0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (int n = 0; n < 14; n++) begin
      if (rows[n].wr) begin
        drain();
        set_config(rows[n].xl, rows[n].yl, rows[n].xs, rows[n].ys, rows[n].mi);
      end
      send_word(rows[n].w, rows[n].known, rows[n].res);
    end

    // random part: one register setting per phase, idling mode rotates
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph % 5)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        3: begin idle_pct = 10; stall_pct = 10; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 9) begin
        rxl = $urandom;
        ryl = $urandom;
        rxs = $urandom;
        rys = $urandom;
      end else begin
        // mostly the interesting part of the plane
        rxl = 32'hd0000000 + $urandom_range(32'h40000000, 0);
        ryl = 32'he0000000 + $urandom_range(32'h20000000, 0);
        rxs = $urandom_range(32'h00400000, 0);
        rys = (ph == 4) ? 32'd0 : $urandom_range(32'h00040000, 0);
      end
      rmi = 16'($urandom_range(48, 1));
      set_config(rxl, ryl, rxs, rys, rmi);
      for (int n = 0; n < 125; n++) begin
        send_word({12'($urandom), 12'($urandom)}, 1'b0, '0);
      end
    end

    // long hold-off on the result side while words keep coming, so the input stalls
    drain();
    idle_pct = 0;
    stall_pct = 0;
    set_config(32'he0000000, 32'hf0000000, 32'h00200000, 32'h00200000, 16'd8);
    hold_req++;
    for (int n = 0; n < 8; n++) begin
      send_word({12'($urandom), 12'($urandom_range(255, 0))}, 1'b0, '0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mbe_pkg.sv
rtl/core/mbe_lane.sv
rtl/core/mandelbrot_escape_time_4lane_unit.sv
dv/mandelbrot_escape_time_4lane_unit_tb.sv
